### design/plmc_pkg.sv
package plmc_pkg;

	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS  = 16;

	localparam int PTR_W    = $clog2(MAX_POINTS);
	localparam int CNT_W    = 5;
	localparam int COLOR_W  = 8;
	localparam int RGB_W    = 3 * COLOR_W;
	localparam int POS_W    = FRAC_BITS + 1;
	localparam int SAMPLE_W = 32;
	localparam int DIV_W    = SAMPLE_W + 1;
	localparam int DCNT_W   = $clog2(FRAC_BITS + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [POS_W-1:0] ONE = POS_W'(1) << FRAC_BITS;

	localparam logic [1:0] OP_SCAN = 2'd0;
	localparam logic [1:0] OP_MAP  = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVALID_RED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVALID_GREEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVALID_BLUE  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM_GO,
		S_NORM_WAIT,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_LEFT_RD,
		S_RIGHT_RD,
		S_RIGHT_CAP,
		S_FRAC_GO,
		S_FRAC_WAIT,
		S_BLEND,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [DIV_W-1:0] num;
		logic signed [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               en;
		logic [PTR_W-1:0]   addr;
		logic [POS_W-1:0]   pos;
		logic [RGB_W-1:0]   color;
	} pt_wr_t;

endpackage

### design/plmc_div.sv
module plmc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plmc_pkg::div_req_t            req,
	output logic                          done,
	output logic [plmc_pkg::POS_W-1:0]    quo
);

	logic                              busy_q;
	logic                              done_q;
	logic [plmc_pkg::DCNT_W-1:0]       cnt_q;
	logic [plmc_pkg::DIV_W-1:0]        rem_q;
	logic [plmc_pkg::DIV_W-1:0]        den_q;
	logic [plmc_pkg::POS_W-1:0]        quo_q;

	logic [plmc_pkg::DIV_W:0]          shifted;
	logic [plmc_pkg::DIV_W:0]          diff;
	logic                              ge;
	logic                              den_bad;
	logic                              num_bad;

	// One quotient bit per cycle while busy; during the iteration the remainder stays below the divisor.
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
		den_bad = req.den[plmc_pkg::DIV_W-1] || (req.den == '0);
		num_bad = req.num[plmc_pkg::DIV_W-1] || (req.num == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (den_bad || num_bad || (req.num >= req.den)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= plmc_pkg::DCNT_W'(plmc_pkg::FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == plmc_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			if (den_bad || num_bad) begin
				quo_q <= '0;
			end else if (req.num >= req.den) begin
				quo_q <= plmc_pkg::ONE;
			end else begin
				quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[plmc_pkg::DIV_W-1:0] : shifted[plmc_pkg::DIV_W-1:0];
			quo_q <= {quo_q[plmc_pkg::POS_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### design/plmc_ram.sv
module plmc_ram (
	input  logic                          clk,
	input  plmc_pkg::pt_wr_t              wr,
	input  logic [plmc_pkg::PTR_W-1:0]    rd_addr,
	output logic [plmc_pkg::POS_W-1:0]    rd_pos,
	output logic [plmc_pkg::RGB_W-1:0]    rd_color
);

	logic [plmc_pkg::POS_W+plmc_pkg::RGB_W-1:0] mem_q [plmc_pkg::MAX_POINTS];
	logic [plmc_pkg::POS_W+plmc_pkg::RGB_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= {wr.pos, wr.color};
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_pos   = rd_q[plmc_pkg::POS_W+plmc_pkg::RGB_W-1:plmc_pkg::RGB_W];
	assign rd_color = rd_q[plmc_pkg::RGB_W-1:0];

endmodule

### design/piecewise_linear_colormap_top.sv
// Channel   Direction  Handshake            Payload
// item      in         item_valid/stall     op, sample, first_of_pass, good, point_*
// result    out        result_valid/stall   red, green, blue, was_masked
// cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// Scan and load requests are handled on acceptance; a masked map request goes straight to
// output. A full one makes two passes through the bit-serial divider (a pass skips its
// iteration when the ratio saturates), a binary search on the memory's registered read
// port, a fetch of both neighboring points and a blend of each channel on one multiplier.
// Reset sets min/max and the config and control registers; the point memory is not cleared.
// A finished result waits in the output register while the next request is taken.
module piecewise_linear_colormap_top (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [1:0]                           op,
	input  logic signed [plmc_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 first_of_pass,
	input  logic                                 good,
	input  logic [3:0]                           point_index,
	input  logic [plmc_pkg::POS_W-1:0]           point_position,
	input  logic [plmc_pkg::COLOR_W-1:0]         point_red,
	input  logic [plmc_pkg::COLOR_W-1:0]         point_green,
	input  logic [plmc_pkg::COLOR_W-1:0]         point_blue,

	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [plmc_pkg::COLOR_W-1:0]         red,
	output logic [plmc_pkg::COLOR_W-1:0]         green,
	output logic [plmc_pkg::COLOR_W-1:0]         blue,
	output logic                                 was_masked,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [plmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [plmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	plmc_pkg::state_t state_q, state_d;

	logic [plmc_pkg::CNT_W-1:0]            point_count_q;
	logic [plmc_pkg::COLOR_W-1:0]          inv_red_q, inv_green_q, inv_blue_q;
	logic signed [plmc_pkg::SAMPLE_W-1:0]  data_min_q, data_max_q;

	logic signed [plmc_pkg::SAMPLE_W-1:0]  sample_q;
	logic                                  masked_q;
	logic [plmc_pkg::POS_W-1:0]            n_q;
	logic [plmc_pkg::PTR_W-1:0]            lo_q, hi_q;
	logic [plmc_pkg::POS_W-1:0]            pos_l_q, pos_r_q;
	logic [plmc_pkg::RGB_W-1:0]            col_l_q, col_r_q;
	logic [plmc_pkg::POS_W-1:0]            f_q;
	logic [1:0]                            blend_cnt_q;
	logic [plmc_pkg::COLOR_W-1:0]          mix_r_q, mix_g_q, mix_b_q;

	logic                                  result_valid_q;
	logic [plmc_pkg::COLOR_W-1:0]          red_q, green_q, blue_q;
	logic                                  was_masked_q;

	logic                                  accept;
	logic                                  out_free;
	logic [plmc_pkg::CNT_W-1:0]            count_eff;
	logic [plmc_pkg::PTR_W-1:0]            mid;
	logic [plmc_pkg::PTR_W-1:0]            lo_n, hi_n;
	logic                                  go_right;
	logic [plmc_pkg::PTR_W-1:0]            left_idx, right_idx;
	logic [plmc_pkg::PTR_W-1:0]            rd_addr;

	plmc_pkg::div_req_t                    div_req;
	logic                                  div_done;
	logic [plmc_pkg::POS_W-1:0]            div_quo;
	plmc_pkg::pt_wr_t                      pt_wr;
	logic [plmc_pkg::POS_W-1:0]            rd_pos;
	logic [plmc_pkg::RGB_W-1:0]            rd_color;

	logic [plmc_pkg::COLOR_W-1:0]          cl, cr;
	logic signed [plmc_pkg::COLOR_W:0]     cdiff;
	logic signed [plmc_pkg::COLOR_W+plmc_pkg::POS_W+1:0] prod;
	logic signed [plmc_pkg::COLOR_W+plmc_pkg::POS_W+1:0] mix_full;

	assign accept    = item_valid && !item_stall;
	assign out_free  = !result_valid_q || !result_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (point_count_q < plmc_pkg::CNT_W'(2)) begin
			count_eff = plmc_pkg::CNT_W'(2);
		end else if (32'(point_count_q) > plmc_pkg::MAX_POINTS) begin
			count_eff = plmc_pkg::CNT_W'(plmc_pkg::MAX_POINTS);
		end else begin
			count_eff = point_count_q;
		end
	end

	always_comb begin
		mid      = plmc_pkg::PTR_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
		go_right = (n_q > rd_pos);
		lo_n     = go_right ? mid + 1'b1 : lo_q;
		hi_n     = go_right ? hi_q : mid;
		// A search that ends at the first point uses the first bin.
		if (lo_q == '0) begin
			left_idx  = '0;
			right_idx = plmc_pkg::PTR_W'(1);
		end else begin
			left_idx  = lo_q - 1'b1;
			right_idx = lo_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			plmc_pkg::S_IDLE: begin
				if (accept && op == plmc_pkg::OP_MAP) begin
					state_d = good ? plmc_pkg::S_NORM_GO : plmc_pkg::S_OUT;
				end
			end
			plmc_pkg::S_NORM_GO:   state_d = plmc_pkg::S_NORM_WAIT;
			plmc_pkg::S_NORM_WAIT: begin
				if (div_done) begin
					state_d = plmc_pkg::S_SRCH_RD;
				end
			end
			plmc_pkg::S_SRCH_RD:   state_d = plmc_pkg::S_SRCH_CMP;
			plmc_pkg::S_SRCH_CMP: begin
				state_d = (lo_n < hi_n) ? plmc_pkg::S_SRCH_RD : plmc_pkg::S_LEFT_RD;
			end
			plmc_pkg::S_LEFT_RD:   state_d = plmc_pkg::S_RIGHT_RD;
			plmc_pkg::S_RIGHT_RD:  state_d = plmc_pkg::S_RIGHT_CAP;
			plmc_pkg::S_RIGHT_CAP: state_d = plmc_pkg::S_FRAC_GO;
			plmc_pkg::S_FRAC_GO:   state_d = plmc_pkg::S_FRAC_WAIT;
			plmc_pkg::S_FRAC_WAIT: begin
				if (div_done) begin
					state_d = plmc_pkg::S_BLEND;
				end
			end
			plmc_pkg::S_BLEND: begin
				if (blend_cnt_q == 2'd2) begin
					state_d = plmc_pkg::S_OUT;
				end
			end
			plmc_pkg::S_OUT: begin
				if (out_free) begin
					state_d = plmc_pkg::S_IDLE;
				end
			end
			default: state_d = plmc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		item_stall  = (state_q != plmc_pkg::S_IDLE);
		div_req     = '0;
		rd_addr     = mid;
		case (state_q)
			plmc_pkg::S_NORM_GO: begin
				div_req.start = 1'b1;
				div_req.num   = {sample_q[plmc_pkg::SAMPLE_W-1], sample_q}
				              - {data_min_q[plmc_pkg::SAMPLE_W-1], data_min_q};
				div_req.den   = {data_max_q[plmc_pkg::SAMPLE_W-1], data_max_q}
				              - {data_min_q[plmc_pkg::SAMPLE_W-1], data_min_q};
			end
			plmc_pkg::S_FRAC_GO: begin
				div_req.start = 1'b1;
				div_req.num   = plmc_pkg::DIV_W'({1'b0, n_q})
				              - plmc_pkg::DIV_W'({1'b0, pos_l_q});
				div_req.den   = plmc_pkg::DIV_W'({1'b0, pos_r_q})
				              - plmc_pkg::DIV_W'({1'b0, pos_l_q});
			end
			plmc_pkg::S_LEFT_RD:  rd_addr = left_idx;
			plmc_pkg::S_RIGHT_RD: rd_addr = right_idx;
			default: begin
				rd_addr = mid;
			end
		endcase
	end

	always_comb begin
		pt_wr.en    = accept && (op == plmc_pkg::OP_LOAD)
		              && (32'(point_index) < plmc_pkg::MAX_POINTS);
		pt_wr.addr  = plmc_pkg::PTR_W'(point_index);
		pt_wr.pos   = point_position;
		pt_wr.color = {point_red, point_green, point_blue};
	end

	// c_l*(1-f) + c_r*f over 2^F equals c_l plus the floored (c_r-c_l)*f over 2^F.
	always_comb begin
		case (blend_cnt_q)
			2'd0: begin
				cl = col_l_q[3*plmc_pkg::COLOR_W-1:2*plmc_pkg::COLOR_W];
				cr = col_r_q[3*plmc_pkg::COLOR_W-1:2*plmc_pkg::COLOR_W];
			end
			2'd1: begin
				cl = col_l_q[2*plmc_pkg::COLOR_W-1:plmc_pkg::COLOR_W];
				cr = col_r_q[2*plmc_pkg::COLOR_W-1:plmc_pkg::COLOR_W];
			end
			default: begin
				cl = col_l_q[plmc_pkg::COLOR_W-1:0];
				cr = col_r_q[plmc_pkg::COLOR_W-1:0];
			end
		endcase
		cdiff    = $signed({1'b0, cr}) - $signed({1'b0, cl});
		prod     = cdiff * $signed({1'b0, f_q});
		mix_full = (prod >>> plmc_pkg::FRAC_BITS)
		         + $signed((plmc_pkg::COLOR_W+plmc_pkg::POS_W+2)'({1'b0, cl}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= plmc_pkg::S_IDLE;
			point_count_q  <= plmc_pkg::CNT_W'(2);
			inv_red_q      <= '0;
			inv_green_q    <= '0;
			inv_blue_q     <= '0;
			data_min_q     <= '0;
			data_max_q     <= '0;
			result_valid_q <= 1'b0;
			blend_cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					plmc_pkg::CFG_POINT_COUNT:   point_count_q <= cfg_data[plmc_pkg::CNT_W-1:0];
					plmc_pkg::CFG_INVALID_RED:   inv_red_q     <= cfg_data;
					plmc_pkg::CFG_INVALID_GREEN: inv_green_q   <= cfg_data;
					plmc_pkg::CFG_INVALID_BLUE:  inv_blue_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept && op == plmc_pkg::OP_SCAN) begin
				if (first_of_pass) begin
					data_min_q <= sample;
					data_max_q <= sample;
				end else begin
					if (sample < data_min_q) begin
						data_min_q <= sample;
					end
					if (sample > data_max_q) begin
						data_max_q <= sample;
					end
				end
			end
			if (state_q == plmc_pkg::S_BLEND) begin
				blend_cnt_q <= (blend_cnt_q == 2'd2) ? 2'd0 : blend_cnt_q + 1'b1;
			end
			if (state_q == plmc_pkg::S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			masked_q <= !good;
		end
		case (state_q)
			plmc_pkg::S_NORM_WAIT: begin
				n_q  <= div_quo;
				lo_q <= '0;
				hi_q <= plmc_pkg::PTR_W'(count_eff - 1'b1);
			end
			plmc_pkg::S_SRCH_CMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
			plmc_pkg::S_RIGHT_RD: begin
				pos_l_q <= rd_pos;
				col_l_q <= rd_color;
			end
			plmc_pkg::S_RIGHT_CAP: begin
				pos_r_q <= rd_pos;
				col_r_q <= rd_color;
			end
			plmc_pkg::S_FRAC_WAIT: f_q <= div_quo;
			plmc_pkg::S_BLEND: begin
				case (blend_cnt_q)
					2'd0:    mix_r_q <= mix_full[plmc_pkg::COLOR_W-1:0];
					2'd1:    mix_g_q <= mix_full[plmc_pkg::COLOR_W-1:0];
					default: mix_b_q <= mix_full[plmc_pkg::COLOR_W-1:0];
				endcase
			end
			default: begin
			end
		endcase
		if (state_q == plmc_pkg::S_OUT && out_free) begin
			was_masked_q <= masked_q;
			red_q        <= masked_q ? inv_red_q   : mix_r_q;
			green_q      <= masked_q ? inv_green_q : mix_g_q;
			blue_q       <= masked_q ? inv_blue_q  : mix_b_q;
		end
	end

	assign result_valid = result_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign was_masked   = was_masked_q;

	plmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	plmc_ram u_ram (
		.clk      (clk),
		.wr       (pt_wr),
		.rd_addr  (rd_addr),
		.rd_pos   (rd_pos),
		.rd_color (rd_color)
	);

endmodule
